FILE: hw/rtl/rese_pkg.sv
`default_nettype none
package rese_pkg;

  localparam int SP_W       = 14;
  localparam int WIN_W      = 16;
  localparam int TICK_IN_W  = 16;
  localparam int CODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_SETPOINT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAST_WINDOW  = 2'd1;

  localparam logic [SP_W-1:0]  MAX_SETPOINT_RST = 14'd1000;
  localparam logic [WIN_W-1:0] FAST_WINDOW_RST  = 16'd2;

  localparam logic [SP_W-1:0] FINE_STEP   = 14'd10;
  localparam logic [SP_W-1:0] COARSE_STEP = 14'd100;

  // encoder transitions that move the setpoint
  localparam logic [CODE_W-1:0] UP_FROM   = 2'd0;
  localparam logic [CODE_W-1:0] UP_TO     = 2'd2;
  localparam logic [CODE_W-1:0] DOWN_FROM = 2'd1;
  localparam logic [CODE_W-1:0] DOWN_TO   = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0]    gray_code;
    logic [TICK_IN_W-1:0] tick_count;
  } sample_t;

  typedef struct packed {
    logic [SP_W-1:0] setpoint;
    logic            changed;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rotary_encoder_setpoint_accel_top.sv
// result: registered, valid in the cycle after its sample item is accepted
// throughput: one item per cycle while result_ready is high; the setpoint
//   update is a single add and compare stage feeding the result register
// reset: synchronous active-high rst clears setpoint, stored code and tick,
//   restores max_setpoint to 1000 and fast_window to 2
`default_nettype none
module rotary_encoder_setpoint_accel_top #(
  parameter int TICK_BITS = 16
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 sample_valid,
  output logic                                sample_ready,
  input  rese_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  wire                                 result_ready,
  output rese_pkg::result_t                   result,
  input  wire                                 cfg_valid,
  output logic                                cfg_ready,
  input  wire [rese_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [rese_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rese_pkg::*;

  localparam int GAP_EXT_W = TICK_BITS + WIN_W;

  logic [SP_W-1:0]      max_setpoint;
  logic [WIN_W-1:0]     fast_window;
  logic [CODE_W-1:0]    last_code;
  logic [SP_W-1:0]      setpoint_value;
  logic [TICK_BITS-1:0] last_change_tick;

  logic [SP_W-1:0]      setpoint_next;
  logic                 changed_next;
  logic [TICK_BITS+TICK_IN_W-1:0] tick_ext;
  logic [TICK_BITS-1:0] tick_in;
  logic [TICK_BITS-1:0] gap;
  logic [GAP_EXT_W-1:0] gap_ext;
  logic [GAP_EXT_W-1:0] win_ext;
  logic                 fast;
  logic                 code_diff;
  logic                 move_up;
  logic                 move_down;
  logic [SP_W:0]        sum_fine;
  logic [SP_W:0]        sum_coarse;
  logic [SP_W:0]        limit;
  logic                 accept;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;

  // setpoint only ever moves by 10 or 100 from zero, so it is always a multiple of 10
  always_comb begin
    tick_ext   = {{TICK_BITS{1'b0}}, sample.tick_count};
    tick_in    = tick_ext[TICK_BITS-1:0];
    gap        = tick_in - last_change_tick;
    gap_ext    = {{WIN_W{1'b0}}, gap};
    win_ext    = {{TICK_BITS{1'b0}}, fast_window};
    fast       = gap_ext < win_ext;
    code_diff  = sample.gray_code != last_code;
    move_up    = (last_code == UP_FROM) && (sample.gray_code == UP_TO);
    move_down  = (last_code == DOWN_FROM) && (sample.gray_code == DOWN_TO);
    sum_fine   = {1'b0, setpoint_value} + {1'b0, FINE_STEP};
    sum_coarse = {1'b0, setpoint_value} + {1'b0, COARSE_STEP};
    limit      = {1'b0, max_setpoint};

    setpoint_next = setpoint_value;
    changed_next  = 1'b0;
    if (move_up && sum_fine <= limit) begin
      changed_next = 1'b1;
      if (fast && sum_coarse <= limit) begin
        setpoint_next = sum_coarse[SP_W-1:0];
      end else begin
        setpoint_next = sum_fine[SP_W-1:0];
      end
    end else if (move_down && setpoint_value >= FINE_STEP) begin
      changed_next = 1'b1;
      if (fast && setpoint_value >= COARSE_STEP) begin
        setpoint_next = setpoint_value - COARSE_STEP;
      end else begin
        setpoint_next = setpoint_value - FINE_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_setpoint     <= MAX_SETPOINT_RST;
      fast_window      <= FAST_WINDOW_RST;
      last_code        <= '0;
      setpoint_value   <= '0;
      last_change_tick <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_SETPOINT: max_setpoint <= cfg_data[SP_W-1:0];
          REG_FAST_WINDOW:  fast_window  <= cfg_data[WIN_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        setpoint_value <= setpoint_next;
        if (code_diff) begin
          last_code        <= sample.gray_code;
          last_change_tick <= tick_in;
        end
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.setpoint <= setpoint_next;
      result.changed  <= changed_next;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/rese_checker.sv
`default_nettype none
module rese_checker (
  input wire                            clk,
  input wire                            rst,
  input wire                            sample_ready,
  input wire                            result_valid,
  input wire                            result_ready,
  input rese_pkg::result_t              result
);
  import rese_pkg::*;

  logic [SP_W-1:0] last_sp;
  logic            out_take;

  assign out_take = result_valid && result_ready;

  // setpoint of the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sp <= '0;
    end else if (out_take) begin
      last_sp <= result.setpoint;
    end
  end

  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    !result_valid |-> sample_ready)
    else $error("sample not taken while result stage empty");

  assert property (@(posedge clk) disable iff (rst)
    (out_take && !result.changed) |-> (result.setpoint == last_sp))
    else $error("setpoint moved without changed");

  assert property (@(posedge clk) disable iff (rst)
    (out_take && result.changed) |-> (result.setpoint != last_sp))
    else $error("changed set but setpoint held");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result item dropped or altered");

endmodule

bind rotary_encoder_setpoint_accel_top rese_checker u_rese_checker (.*);
`default_nettype wire

FILE: tb/sv/setpoint_checker.sv
module setpoint_checker (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             sample_valid,
  input  wire                             sample_ready,
  input  rese_pkg::sample_t               sample,
  input  wire                             result_valid,
  input  wire                             result_ready,
  input  rese_pkg::result_t               result,
  input  wire                             cfg_valid,
  input  wire                             cfg_ready,
  input  wire [rese_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [rese_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              results_seen,
  output int                              moves
);
  import rese_pkg::*;

  logic [SP_W-1:0]      limit_sp;
  logic [WIN_W-1:0]     window;
  logic [CODE_W-1:0]    held_code;
  logic [SP_W-1:0]      setpoint_now;
  logic [TICK_IN_W-1:0] change_tick;
  result_t              setpoint_q[$];
  int                   n_bad;
  int                   n_seen;
  int                   n_moves;

  function automatic result_t step_setpoint(sample_t s);
    int                   sp;
    logic [TICK_IN_W-1:0] gap;
    logic                 fast;
    result_t              r;
    sp = (int'(setpoint_now) / int'(FINE_STEP)) * int'(FINE_STEP);
    r.changed = 1'b0;
    if (s.gray_code != held_code) begin
      // tick gap wraps with the 16-bit timer
      gap = s.tick_count - change_tick;
      fast = gap < window;
      if (held_code == UP_FROM && s.gray_code == UP_TO) begin
        if (sp + int'(FINE_STEP) <= int'(limit_sp)) begin
          if (fast && sp + int'(COARSE_STEP) <= int'(limit_sp)) begin
            sp += int'(COARSE_STEP);
          end else begin
            sp += int'(FINE_STEP);
          end
          r.changed = 1'b1;
        end
      end else if (held_code == DOWN_FROM && s.gray_code == DOWN_TO) begin
        if (sp >= int'(FINE_STEP)) begin
          if (fast && sp >= int'(COARSE_STEP)) begin
            sp -= int'(COARSE_STEP);
          end else begin
            sp -= int'(FINE_STEP);
          end
          r.changed = 1'b1;
        end
      end
      held_code = s.gray_code;
      change_tick = s.tick_count;
    end
    setpoint_now = sp[SP_W-1:0];
    r.setpoint = setpoint_now;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      limit_sp = MAX_SETPOINT_RST;
      window = FAST_WINDOW_RST;
      held_code = '0;
      setpoint_now = '0;
      change_tick = '0;
      setpoint_q.delete();
      n_bad = 0;
      n_seen = 0;
      n_moves = 0;
    end else begin
      if (result_valid && result_ready) begin
        n_seen++;
        if (setpoint_q.size() == 0) begin
          if (n_bad < 10) begin
            $display("unexpected result item: setpoint %0d changed %0b",
                     result.setpoint, result.changed);
          end
          n_bad++;
        end else begin
          want = setpoint_q.pop_front();
          if (want.changed) begin
            n_moves++;
          end
          if (result.setpoint !== want.setpoint || result.changed !== want.changed) begin
            if (n_bad < 10) begin
              $display("mismatch on result %0d: setpoint exp %0d got %0d, changed exp %0b got %0b",
                       n_seen, want.setpoint, result.setpoint, want.changed, result.changed);
            end
            n_bad++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_SETPOINT: begin
            limit_sp = cfg_data[SP_W-1:0];
          end
          REG_FAST_WINDOW: begin
            window = cfg_data[WIN_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (sample_valid && sample_ready) begin
        setpoint_q.push_back(step_setpoint(sample));
      end
    end
    mismatches <= n_bad;
    pending <= setpoint_q.size();
    results_seen <= n_seen;
    moves <= n_moves;
  end

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import rese_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int MAX_WAIT   = 17;

  typedef enum int {WALK_UP, WALK_DOWN, NOISE} walk_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  sample_valid = 1'b0;
  sample_t               sample = '0;
  logic                  result_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  wire                   sample_ready;
  wire                   result_valid;
  wire                   cfg_ready;
  result_t               result;

  int mismatches;
  int pending;
  int results_seen;
  int moves;

  int                   sent = 0;
  int                   cfg_writes = 0;
  int                   settings = 0;
  int                   idle_cycles = 0;
  bit                   drive_busy = 1'b0;
  logic [CODE_W-1:0]    prev_code = UP_FROM;
  logic [TICK_IN_W-1:0] tick_now = '0;
  logic [WIN_W-1:0]     cur_window = FAST_WINDOW_RST;
  walk_e                walk = NOISE;

  rotary_encoder_setpoint_accel_top #(
    .TICK_BITS(16)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  setpoint_checker u_checker (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatches(mismatches),
    .pending(pending),
    .results_seen(results_seen),
    .moves(moves)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic send_sample(input logic [CODE_W-1:0] code, input logic [TICK_IN_W-1:0] tick);
    int      w;
    sample_t s;
    if ($urandom_range(0, 29) == 0) begin
      drive_busy = !drive_busy;
    end
    w = drive_busy ? 0 : $urandom_range(0, MAX_WAIT);
    s.gray_code = code;
    s.tick_count = tick;
    if (w > 0) begin
      sample_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (!(sample_valid && sample_ready));
    sent++;
    prev_code = code;
  endtask

  task automatic pick_walk(input int up_pct, input int down_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < up_pct) begin
      walk = WALK_UP;
    end else if (r < up_pct + down_pct) begin
      walk = WALK_DOWN;
    end else begin
      walk = NOISE;
    end
  endtask

  task automatic random_sample(input int up_pct, input int down_pct);
    int                r;
    int                g;
    logic [CODE_W-1:0] code;
    if ($urandom_range(0, 11) == 0) begin
      pick_walk(up_pct, down_pct);
    end
    case (walk)
      WALK_UP: begin
        code = (prev_code == UP_TO) ? UP_FROM : UP_TO;
      end
      WALK_DOWN: begin
        code = (prev_code == DOWN_FROM) ? DOWN_TO : DOWN_FROM;
      end
      default: begin
        code = CODE_W'($urandom_range(0, 2**CODE_W - 1));
      end
    endcase
    if ($urandom_range(0, 7) == 0) begin
      code = prev_code;
    end
    // tick gaps: short, around the window edge, or anywhere
    r = $urandom_range(0, 9);
    if (r < 5) begin
      g = $urandom_range(0, 3);
    end else if (r < 8) begin
      g = int'(cur_window) + int'($urandom_range(0, 3)) - 2;
    end else begin
      g = $urandom_range(0, 65535);
    end
    tick_now = tick_now + g[TICK_IN_W-1:0];
    send_sample(code, tick_now);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_writes++;
    if (idx == REG_FAST_WINDOW) begin
      cur_window = val[WIN_W-1:0];
    end
  endtask

  task automatic drain;
    sample_valid <= 1'b0;
    while (results_seen < sent) @(posedge clk);
  endtask

  task automatic run_phase(input int n, input int up_pct, input int down_pct);
    cfg_valid <= 1'b0;
    settings++;
    pick_walk(up_pct, down_pct);
    repeat (n) random_sample(up_pct, down_pct);
    drain();
  endtask

  // result side: random stalls with stretches of steady ready
  initial begin
    int w;
    bit take_busy;
    take_busy = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 29) == 0) begin
        take_busy = !take_busy;
      end
      w = take_busy ? 0 : $urandom_range(0, MAX_WAIT);
      if (w > 0) begin
        result_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!(result_valid && result_ready));
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((sample_valid && sample_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int failures;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset limits: max 1000, window 2
    settings++;
    send_sample(UP_FROM,   16'h0000);
    send_sample(DOWN_TO,   16'h0001);
    send_sample(DOWN_FROM, 16'h0002);
    send_sample(DOWN_TO,   16'h0003);
    send_sample(UP_FROM,   16'h0004);
    send_sample(UP_TO,     16'h0005);
    send_sample(UP_FROM,   16'h0006);
    send_sample(UP_TO,     16'h0008);
    send_sample(UP_FROM,   16'hFFFF);
    send_sample(UP_TO,     16'h0000);
    send_sample(UP_TO,     16'hABCD);
    send_sample(UP_FROM,   16'h5432);
    send_sample(UP_TO,     16'h5433);
    send_sample(DOWN_FROM, 16'h8000);
    send_sample(DOWN_TO,   16'h8001);
    send_sample(DOWN_FROM, 16'h7FFF);
    send_sample(DOWN_TO,   16'h7FFE);
    send_sample(DOWN_FROM, 16'hFFFF);
    send_sample(DOWN_TO,   16'h0000);
    send_sample(DOWN_FROM, 16'h0001);
    send_sample(DOWN_TO,   16'h0002);
    send_sample(UP_FROM,   16'h0003);
    send_sample(UP_TO,     16'h1234);
    tick_now = 16'h1234;
    drain();

    write_reg(REG_MAX_SETPOINT, 16'hFFFF);
    write_reg(REG_FAST_WINDOW, 16'hFFFF);
    write_reg(REG_SPARE_LO, 16'($urandom));
    run_phase(250, 80, 10);

    // limit dropped below the setpoint
    write_reg(REG_MAX_SETPOINT, 16'hC03C);
    write_reg(REG_FAST_WINDOW, 16'h8000);
    run_phase(200, 5, 85);

    write_reg(REG_MAX_SETPOINT, 16'h0000);
    write_reg(REG_FAST_WINDOW, 16'h0000);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    run_phase(60, 40, 40);

    write_reg(REG_MAX_SETPOINT, 16'd250);
    run_phase(100, 70, 15);

    write_reg(REG_MAX_SETPOINT, 16'h3FFF);
    write_reg(REG_FAST_WINDOW, 16'd5);
    run_phase(100, 45, 45);

    repeat (3) @(posedge clk);
    failures = mismatches + pending;
    $display("covered %0d samples under %0d limit settings with %0d register writes",
             sent, settings, cfg_writes);
    $display("setpoint moved on %0d of %0d results", moves, results_seen);
    if (failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
